// ===== hw/rtl/pair_dictionary_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Pair dictionary decoder assertion macros
// Shared concurrent assertion forms, sampled on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PAIR_DICTIONARY_DECODER_DEFINES_SVH
`define PAIR_DICTIONARY_DECODER_DEFINES_SVH

// property must hold at every sampled edge out of reset
`define PDD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// condition must never be seen out of reset
`define PDD_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ===== hw/rtl/pdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair dictionary decoder package
// Codes, marker characters, table sizes and beat types shared by the block.
// ----------------------------------------------------------------------------
package pdd_pkg;

   localparam int TABLE_DEPTH = 127;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int PAIR_W      = 16;
   localparam int MAX_BEATS   = 3;
   localparam int CNT_W       = $clog2(MAX_BEATS + 1);

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_DATA = 2'd1;
   localparam logic [1:0] ACT_END  = 2'd2;

   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CODE_BASE = 8'h81;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       stream_end;
      logic       run_last;
   } rsp_beat_type;

   typedef struct packed {
      logic [CNT_W-1:0]                  count;
      rsp_beat_type [MAX_BEATS-1:0]      beat;
   } beat_list_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] in_byte;
      logic       entry_hit;
   } item_type;

   function automatic rsp_beat_type data_beat(input logic [7:0] value);
      rsp_beat_type b;
      b            = '0;
      b.out_byte   = value;
      b.has_byte   = 1'b1;
      return b;
   endfunction

endpackage

// ===== hw/rtl/pdd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair dictionary decoder channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface pdd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] in_byte;
   logic [6:0] entry_index;
   logic [7:0] entry_first;
   logic [7:0] entry_second;

   modport source (output valid, action, in_byte, entry_index, entry_first, entry_second,
                   input ready);
   modport sink   (input valid, action, in_byte, entry_index, entry_first, entry_second,
                   output ready);
endinterface

interface pdd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       stream_end;
   logic       run_last;

   modport source (output valid, out_byte, has_byte, stream_end, run_last, input ready);
   modport sink   (input valid, out_byte, has_byte, stream_end, run_last, output ready);
endinterface

// ===== hw/rtl/pdd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pdd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pdd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair dictionary decoder stream logic
// Marker tracking state and the resolution of one item into its beats.
// ----------------------------------------------------------------------------
`include "pair_dictionary_decoder_defines.svh"

module pdd_decode (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  pdd_pkg::item_type                  item,
   input  logic [pdd_pkg::PAIR_W-1:0]         entry_pair,
   output pdd_pkg::beat_list_type             beat_list
);
   import pdd_pkg::*;

   logic protected_ff, protected_in;
   logic pend_valid_ff, pend_valid_in;
   logic pend_at_ff, pend_at_in;
   logic suppress_ff, suppress_in;

   always_comb begin
      logic [CNT_W-1:0] n;
      logic [7:0]       x;
      logic [7:0]       pend_char;
      logic [7:0]       pair_hi;
      logic [7:0]       pair_lo;
      logic             eff_suppress;

      beat_list     = '0;
      protected_in  = protected_ff;
      pend_valid_in = pend_valid_ff;
      pend_at_in    = pend_at_ff;
      suppress_in   = suppress_ff;
      n             = '0;
      x             = item.in_byte;
      pend_char     = pend_at_ff ? CH_AT : CH_LT;
      pair_hi       = item.entry_hit ? entry_pair[15:8] : 8'h00;
      pair_lo       = item.entry_hit ? entry_pair[7:0]  : 8'h00;
      eff_suppress  = suppress_ff && !pend_valid_ff;

      unique case (item.action)
         ACT_DATA: begin
            if (pend_valid_ff && !pend_at_ff && x == CH_AT) begin
               pend_valid_in = 1'b0;
               protected_in  = 1'b1;
               suppress_in   = 1'b1;
            end else if (pend_valid_ff && pend_at_ff && x == CH_GT) begin
               pend_valid_in = 1'b0;
               protected_in  = 1'b0;
               suppress_in   = 1'b1;
            end else begin
               if (pend_valid_ff) begin
                  beat_list.beat[0] = data_beat(pend_char);
                  n                 = CNT_W'(1);
               end
               pend_valid_in = 1'b0;
               suppress_in   = 1'b0;
               if (!eff_suppress && x == CH_LT) begin
                  pend_valid_in = 1'b1;
                  pend_at_in    = 1'b0;
               end else if (protected_ff && x == CH_AT) begin
                  pend_valid_in = 1'b1;
                  pend_at_in    = 1'b1;
               end else if (!protected_ff && x >= CODE_BASE) begin
                  beat_list.beat[n]               = data_beat(pair_hi);
                  beat_list.beat[CNT_W'(n + 1'b1)] = data_beat(pair_lo);
                  n                               = CNT_W'(n + 2'd2);
               end else begin
                  beat_list.beat[n] = data_beat(x);
                  n                 = CNT_W'(n + 1'b1);
               end
            end
            if (n != '0) begin
               beat_list.beat[CNT_W'(n - 1'b1)].run_last = 1'b1;
            end
         end
         ACT_END: begin
            if (pend_valid_ff) begin
               beat_list.beat[0] = data_beat(pend_char);
            end
            beat_list.beat[0].stream_end = 1'b1;
            beat_list.beat[0].run_last   = 1'b1;
            n             = CNT_W'(1);
            protected_in  = 1'b0;
            pend_valid_in = 1'b0;
            pend_at_in    = 1'b0;
            suppress_in   = 1'b0;
         end
         default: begin
         end
      endcase
      beat_list.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protected_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_at_ff    <= 1'b0;
         suppress_ff   <= 1'b0;
      end else if (advance) begin
         protected_ff  <= protected_in;
         pend_valid_ff <= pend_valid_in;
         pend_at_ff    <= pend_at_in;
         suppress_ff   <= suppress_in;
      end
   end

   `PDD_ASSERT_NEVER(a_pend_at_outside, pend_valid_ff && pend_at_ff && !protected_ff, "pending close marker outside protected section")
   `PDD_ASSERT(a_end_one_beat, (advance && item.action == ACT_END) |-> (beat_list.count == CNT_W'(1)), "end item must give exactly one beat")

endmodule

// ===== hw/rtl/pdd_rsp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair dictionary decoder response queue
// Three-slot output register that drains one resolved beat per cycle while rsp is ready.
// ----------------------------------------------------------------------------
`include "pair_dictionary_decoder_defines.svh"

module pdd_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  pdd_pkg::beat_list_type beat_list,
   output logic                   can_load,
   pdd_rsp_if.source              rsp
);
   import pdd_pkg::*;

   logic [CNT_W-1:0]             count_ff, count_in;
   rsp_beat_type [MAX_BEATS-1:0] slot_ff, slot_in;
   logic                         pop;

   assign pop      = rsp.valid && rsp.ready;
   assign can_load = (count_ff == '0) || (count_ff == CNT_W'(1) && pop);

   always_comb begin
      count_in = count_ff;
      slot_in  = slot_ff;
      if (load) begin
         count_in = beat_list.count;
         slot_in  = beat_list.beat;
      end else if (pop) begin
         count_in = CNT_W'(count_ff - 1'b1);
         for (int i = 0; i < MAX_BEATS - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
         slot_in[MAX_BEATS-1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign rsp.valid      = (count_ff != '0);
   assign rsp.out_byte   = slot_ff[0].out_byte;
   assign rsp.has_byte   = slot_ff[0].has_byte;
   assign rsp.stream_end = slot_ff[0].stream_end;
   assign rsp.run_last   = slot_ff[0].run_last;

   `PDD_ASSERT(a_load_when_free, load |-> can_load, "queue loaded while still holding beats")
   `PDD_ASSERT(a_end_is_last, (rsp.valid && rsp.stream_end) |-> rsp.run_last, "end beat not marked last")
   `PDD_ASSERT(a_last_closes, (rsp.valid && rsp.run_last) |-> (count_ff == CNT_W'(1)), "last beat not alone")

endmodule

// ===== hw/rtl/pair_dictionary_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair dictionary decoder
// Streaming byte-pair decoder with protected sections and a loadable table.
//
//   channel   dir   beat contents
//   req_chan  in    action, in_byte, entry_index, entry_first, entry_second
//   rsp_chan  out   out_byte, has_byte, stream_end, run_last
//
// A req beat is registered together with its table read, then resolved
// combinationally into zero to three rsp beats held in a three-slot
// output queue. One rsp beat leaves per cycle while the rsp port is ready,
// and the next item loads as the last beat of one leaves; the rsp port
// sets the rate. Reset clears stream state and the table valid bits.
// req_ready drops only while the item register waits on a busy queue.
// ----------------------------------------------------------------------------
module pair_dictionary_decoder (
   input  logic      clock,
   input  logic      reset,
   pdd_req_if.sink   req_chan,
   pdd_rsp_if.source rsp_chan
);
   import pdd_pkg::*;

   logic                   accept;
   logic                   advance;
   logic                   can_load;
   logic                   s1_valid_ff, s1_valid_in;
   item_type               s1_item_ff, s1_item_in;
   logic [TABLE_DEPTH-1:0] entry_valid_ff;
   logic [IDX_W-1:0]       rd_idx;
   logic                   wr_en;
   logic [PAIR_W-1:0]      entry_pair;
   beat_list_type          beat_list;

   assign advance        = s1_valid_ff && can_load;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rd_idx = IDX_W'(req_chan.in_byte - CODE_BASE);
   assign wr_en  = accept && (req_chan.action == ACT_LOAD)
                   && (req_chan.entry_index < IDX_W'(TABLE_DEPTH));

   always_comb begin
      s1_item_in.action    = req_chan.action;
      s1_item_in.in_byte   = req_chan.in_byte;
      s1_item_in.entry_hit = (rd_idx < IDX_W'(TABLE_DEPTH)) ? entry_valid_ff[rd_idx] : 1'b0;
      s1_valid_in          = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (wr_en) begin
            entry_valid_ff[req_chan.entry_index] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= s1_item_in;
      end
   end

   pdd_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_pair_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_chan.entry_index),
      .wr_data ({req_chan.entry_first, req_chan.entry_second}),
      .rd_en   (accept),
      .rd_addr (rd_idx),
      .rd_data (entry_pair)
   );

   pdd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (s1_item_ff),
      .entry_pair (entry_pair),
      .beat_list  (beat_list)
   );

   pdd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .beat_list (beat_list),
      .can_load  (can_load),
      .rsp       (rsp_chan)
   );

endmodule
